// File: hw/rtl/abkf_pkg.sv
// Shared types, opcodes, register selects and the update microprogram.
`timescale 1ns / 1ps

package abkf_pkg;

  localparam int FIELD_W = 48;
  localparam int NOISE_W = 47;
  localparam int DT_W    = 32;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_Q_ANGLE      = 3'd0;
  localparam cfg_idx_t CFG_Q_BIAS       = 3'd1;
  localparam cfg_idx_t CFG_R_MEASURE    = 3'd2;
  localparam cfg_idx_t CFG_ANGLE_INIT   = 3'd3;
  localparam cfg_idx_t CFG_BIAS_INIT    = 3'd4;
  localparam cfg_idx_t CFG_P00_INIT     = 3'd5;
  localparam cfg_idx_t CFG_P11_INIT     = 3'd6;
  localparam cfg_idx_t CFG_P_CROSS_INIT = 3'd7;

  localparam logic OPC_UPDATE = 1'b0;
  localparam logic OPC_LOAD   = 1'b1;

  typedef logic [1:0] alu_op_t;
  localparam alu_op_t OP_ADD = 2'd0;
  localparam alu_op_t OP_SUB = 2'd1;
  localparam alu_op_t OP_MUL = 2'd2;
  localparam alu_op_t OP_DIV = 2'd3;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef logic [3:0] reg_sel_t;
  localparam reg_sel_t R_ANGLE = 4'd0;
  localparam reg_sel_t R_BIAS  = 4'd1;
  localparam reg_sel_t R_COVA  = 4'd2;
  localparam reg_sel_t R_COVX  = 4'd3;
  localparam reg_sel_t R_COVB  = 4'd4;
  localparam reg_sel_t R_DT    = 4'd5;
  localparam reg_sel_t R_MA    = 4'd6;
  localparam reg_sel_t R_MR    = 4'd7;
  localparam reg_sel_t R_T     = 4'd8;
  localparam reg_sel_t R_S     = 4'd9;
  localparam reg_sel_t R_K0    = 4'd10;
  localparam reg_sel_t R_K1    = 4'd11;
  localparam reg_sel_t R_Y     = 4'd12;
  localparam reg_sel_t R_QA    = 4'd13;
  localparam reg_sel_t R_QB    = 4'd14;
  localparam reg_sel_t R_RM    = 4'd15;

  typedef struct packed {
    alu_op_t  op;
    reg_sel_t dst;
    reg_sel_t src_a;
    reg_sel_t src_b;
  } step_t;

  localparam int PROG_LEN = 27;
  typedef logic [4:0] pc_t;
  localparam pc_t PC_LAST = 5'd26;

  // predict, gains, correct, covariance update (old cross term used first)
  localparam step_t PROG [PROG_LEN] = '{
    '{OP_SUB, R_T,     R_MR,    R_BIAS},
    '{OP_MUL, R_T,     R_DT,    R_T},
    '{OP_ADD, R_ANGLE, R_ANGLE, R_T},
    '{OP_MUL, R_T,     R_DT,    R_COVB},
    '{OP_SUB, R_T,     R_T,     R_COVX},
    '{OP_SUB, R_T,     R_T,     R_COVX},
    '{OP_ADD, R_T,     R_T,     R_QA},
    '{OP_MUL, R_T,     R_DT,    R_T},
    '{OP_ADD, R_COVA,  R_COVA,  R_T},
    '{OP_MUL, R_T,     R_DT,    R_COVB},
    '{OP_SUB, R_COVX,  R_COVX,  R_T},
    '{OP_MUL, R_T,     R_QB,    R_DT},
    '{OP_ADD, R_COVB,  R_COVB,  R_T},
    '{OP_ADD, R_S,     R_COVA,  R_RM},
    '{OP_DIV, R_K0,    R_COVA,  R_S},
    '{OP_DIV, R_K1,    R_COVX,  R_S},
    '{OP_SUB, R_Y,     R_MA,    R_ANGLE},
    '{OP_MUL, R_T,     R_K0,    R_Y},
    '{OP_ADD, R_ANGLE, R_ANGLE, R_T},
    '{OP_MUL, R_T,     R_K1,    R_Y},
    '{OP_ADD, R_BIAS,  R_BIAS,  R_T},
    '{OP_MUL, R_T,     R_K1,    R_COVX},
    '{OP_SUB, R_COVB,  R_COVB,  R_T},
    '{OP_MUL, R_T,     R_K0,    R_COVX},
    '{OP_SUB, R_COVX,  R_COVX,  R_T},
    '{OP_MUL, R_T,     R_K0,    R_COVA},
    '{OP_SUB, R_COVA,  R_COVA,  R_T}
  };

endpackage

// File: hw/rtl/abkf_alu.sv
// Shared saturating fixed-point unit: add, sub, iterative multiply and divide.
`timescale 1ns / 1ps

module abkf_alu #(
  parameter int WORD_WIDTH = 48,
  parameter int FRAC_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  abkf_pkg::alu_req_t           req,
  input  logic signed [WORD_WIDTH-1:0] a,
  input  logic signed [WORD_WIDTH-1:0] b,
  output logic                         done,
  output logic signed [WORD_WIDTH-1:0] result
);
  import abkf_pkg::*;

  localparam int W   = WORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int CH  = 16;
  localparam int NCH = (W + CH - 1) / CH;
  localparam int YW  = NCH * CH;
  localparam int PW  = W + YW;
  localparam int QW  = W + F;
  localparam int VW  = (PW + 1 > QW) ? PW + 1 : QW;
  localparam int CW  = $clog2(QW + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SAT  = 3'd3;
  localparam logic [2:0] S_NEG  = 3'd4;

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic [2:0]    state;
  logic [CW-1:0] cnt;
  alu_op_t       op_r;
  logic          neg;
  logic [W-1:0]  x;
  logic [PW-1:0] p;
  logic [W-1:0]  r;
  logic [W-1:0]  dv;
  logic [QW-1:0] qd;
  logic [W-1:0]  mag;

  logic [W-1:0]      ua, ub, a_mag, b_mag;
  logic signed [W:0] sa, ss;
  logic signed [W-1:0] add_res, sub_res;
  logic [W+CH-1:0]   pp, acc;
  logic [PW-1:0]     p_next;
  logic [W:0]        rs;
  logic              ge;
  logic [W-1:0]      r_next;
  logic [VW-1:0]     val, lim;
  logic [W-1:0]      mag_next;

  always_comb begin
    ua    = a;
    ub    = b;
    a_mag = a[W-1] ? (~ua + W'(1)) : ua;
    b_mag = b[W-1] ? (~ub + W'(1)) : ub;
    sa    = {a[W-1], a} + {b[W-1], b};
    ss    = {a[W-1], a} - {b[W-1], b};
    add_res = (sa[W] != sa[W-1]) ? (sa[W] ? WMIN : WMAX) : sa[W-1:0];
    sub_res = (ss[W] != ss[W-1]) ? (ss[W] ? WMIN : WMAX) : ss[W-1:0];
    pp     = {{CH{1'b0}}, x} * {{W{1'b0}}, p[CH-1:0]};
    acc    = {{CH{1'b0}}, p[PW-1:YW]} + pp;
    p_next = {acc, p[YW-1:CH]};
    rs     = {r, qd[QW-1]};
    ge     = rs >= {1'b0, dv};
    r_next = ge ? (rs[W-1:0] - dv) : rs[W-1:0];
    if (op_r == OP_MUL) begin
      val = (VW'(p) + (VW'(1) << (F - 1))) >> F;
    end else begin
      val = VW'(qd);
    end
    lim      = (VW'(1) << (W - 1)) - (neg ? VW'(0) : VW'(1));
    mag_next = (val > lim) ? lim[W-1:0] : val[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            op_r <= req.op;
            unique case (req.op)
              OP_ADD: begin
                result <= add_res;
                done   <= 1'b1;
              end
              OP_SUB: begin
                result <= sub_res;
                done   <= 1'b1;
              end
              OP_MUL: begin
                x     <= a_mag;
                p     <= PW'(b_mag);
                neg   <= a[W-1] ^ b[W-1];
                cnt   <= '0;
                done  <= 1'b0;
                state <= S_MUL;
              end
              default: begin
                if (b[W-1] || (b == '0)) begin
                  result <= '0;
                  done   <= 1'b1;
                end else begin
                  neg   <= a[W-1];
                  r     <= '0;
                  dv    <= ub;
                  qd    <= QW'(a_mag) << F;
                  cnt   <= '0;
                  done  <= 1'b0;
                  state <= S_DIV;
                end
              end
            endcase
          end else begin
            done <= 1'b0;
          end
        end
        S_MUL: begin
          p    <= p_next;
          cnt  <= cnt + CW'(1);
          done <= 1'b0;
          if (cnt == CW'(NCH - 1)) state <= S_SAT;
        end
        S_DIV: begin
          r    <= r_next;
          qd   <= {qd[QW-2:0], ge};
          cnt  <= cnt + CW'(1);
          done <= 1'b0;
          if (cnt == CW'(QW - 1)) state <= S_SAT;
        end
        S_SAT: begin
          mag   <= mag_next;
          done  <= 1'b0;
          state <= S_NEG;
        end
        S_NEG: begin
          result <= neg ? (~mag + W'(1)) : mag;
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/angle_bias_kalman_filter_unit.sv
// Top level: angle/gyro-bias Kalman filter, microprogram over one shared ALU.
// Load item: copies the init registers into angle, bias and covariance. Update item:
// runs the microprogram on the ALU, with two divisions and ten multiplies; both
// divisions are skipped when the innovation variance is not positive.
// One item at a time; in_stall stays high until the result is loaded.
// Synchronous reset clears state, covariance and configuration registers to zero.
`timescale 1ns / 1ps

module angle_bias_kalman_filter_unit #(
  parameter int WORD_WIDTH = 48,
  parameter int FRAC_BITS  = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  opcode,
  input  logic signed [abkf_pkg::FIELD_W-1:0]   measured_angle,
  input  logic signed [abkf_pkg::FIELD_W-1:0]   measured_rate,
  input  logic [abkf_pkg::DT_W-1:0]             time_step,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [abkf_pkg::FIELD_W-1:0]   angle_estimate,
  input  logic                                  wr_en,
  input  abkf_pkg::cfg_idx_t                    wr_index,
  input  logic [abkf_pkg::FIELD_W-1:0]          wr_data
);
  import abkf_pkg::*;

  localparam int W      = WORD_WIDTH;
  localparam int DT_SHL = (FRAC_BITS >= 32) ? FRAC_BITS - 32 : 0;
  localparam int DT_SHR = (FRAC_BITS < 32) ? 32 - FRAC_BITS : 0;

  localparam logic signed [64:0] WMAX_L = (65'sd1 <<< (W - 1)) - 65'sd1;
  localparam logic signed [64:0] WMIN_L = -WMAX_L - 65'sd1;
  localparam logic signed [64:0] OMAX_L = 65'sh7FFFFFFFFFFF;
  localparam logic signed [64:0] OMIN_L = -OMAX_L - 65'sd1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  function automatic logic signed [W-1:0] clamp_w(input logic signed [64:0] v);
    logic signed [64:0] c;
    c = v;
    if (v > WMAX_L) c = WMAX_L;
    if (v < WMIN_L) c = WMIN_L;
    return c[W-1:0];
  endfunction

  logic [NOISE_W-1:0]        q_angle, q_bias, r_measure, p00_init, p11_init;
  logic signed [FIELD_W-1:0] angle_init, bias_init, p_cross_init;

  logic [1:0] state;
  pc_t        pc;
  logic signed [W-1:0] angle, bias, cova, covx, covb, dt, ma, mr, t, s, k0, k1, y;
  logic signed [W-1:0] qa, qb, rm, dt_in, alu_a, alu_b, alu_res;
  logic [79:0]         dt_wide;
  logic signed [64:0]  ax;
  logic signed [FIELD_W-1:0] ang_out;
  step_t               cur;
  alu_req_t            alu_req;
  logic                alu_done;

  function automatic logic signed [W-1:0] pick(input reg_sel_t sel,
      input logic signed [W-1:0] v_angle, v_bias, v_cova, v_covx, v_covb, v_dt,
      v_ma, v_mr, v_t, v_s, v_k0, v_k1, v_y, v_qa, v_qb, v_rm);
    logic signed [W-1:0] o;
    unique case (sel)
      R_ANGLE: o = v_angle;
      R_BIAS:  o = v_bias;
      R_COVA:  o = v_cova;
      R_COVX:  o = v_covx;
      R_COVB:  o = v_covb;
      R_DT:    o = v_dt;
      R_MA:    o = v_ma;
      R_MR:    o = v_mr;
      R_T:     o = v_t;
      R_S:     o = v_s;
      R_K0:    o = v_k0;
      R_K1:    o = v_k1;
      R_Y:     o = v_y;
      R_QA:    o = v_qa;
      R_QB:    o = v_qb;
      default: o = v_rm;
    endcase
    return o;
  endfunction

  always_comb begin
    qa      = clamp_w(65'(q_angle));
    qb      = clamp_w(65'(q_bias));
    rm      = clamp_w(65'(r_measure));
    dt_wide = (80'(time_step) << DT_SHL) >> DT_SHR;
    dt_in   = (dt_wide > 80'(WMAX_L[63:0])) ? WMAX_L[W-1:0] : dt_wide[W-1:0];
    cur     = PROG[pc];
    alu_req.start = (state == ST_RUN);
    alu_req.op    = cur.op;
    alu_a = pick(cur.src_a, angle, bias, cova, covx, covb, dt, ma, mr, t, s, k0, k1,
                 y, qa, qb, rm);
    alu_b = pick(cur.src_b, angle, bias, cova, covx, covb, dt, ma, mr, t, s, k0, k1,
                 y, qa, qb, rm);
    ax = 65'(angle);
    if (ax > OMAX_L) ax = OMAX_L;
    if (ax < OMIN_L) ax = OMIN_L;
    ang_out = ax[FIELD_W-1:0];
  end

  assign in_stall = (state != ST_IDLE);

  abkf_alu #(
    .WORD_WIDTH(WORD_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_alu (
    .clk   (clk),
    .rst   (rst),
    .req   (alu_req),
    .a     (alu_a),
    .b     (alu_b),
    .done  (alu_done),
    .result(alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pc           <= '0;
      out_valid    <= 1'b0;
      angle        <= '0;
      bias         <= '0;
      cova         <= '0;
      covx         <= '0;
      covb         <= '0;
      q_angle      <= '0;
      q_bias       <= '0;
      r_measure    <= '0;
      angle_init   <= '0;
      bias_init    <= '0;
      p00_init     <= '0;
      p11_init     <= '0;
      p_cross_init <= '0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          CFG_Q_ANGLE:      q_angle      <= wr_data[NOISE_W-1:0];
          CFG_Q_BIAS:       q_bias       <= wr_data[NOISE_W-1:0];
          CFG_R_MEASURE:    r_measure    <= wr_data[NOISE_W-1:0];
          CFG_ANGLE_INIT:   angle_init   <= wr_data;
          CFG_BIAS_INIT:    bias_init    <= wr_data;
          CFG_P00_INIT:     p00_init     <= wr_data[NOISE_W-1:0];
          CFG_P11_INIT:     p11_init     <= wr_data[NOISE_W-1:0];
          default:          p_cross_init <= wr_data;
        endcase
      end
      if (out_valid && !out_stall && state != ST_DONE) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (opcode == OPC_LOAD) begin
              angle <= clamp_w(65'(angle_init));
              bias  <= clamp_w(65'(bias_init));
              cova  <= clamp_w(65'(p00_init));
              covb  <= clamp_w(65'(p11_init));
              covx  <= clamp_w(65'(p_cross_init));
              state <= ST_DONE;
            end else begin
              ma    <= clamp_w(65'(measured_angle));
              mr    <= clamp_w(65'(measured_rate));
              dt    <= dt_in;
              pc    <= '0;
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: state <= ST_WAIT;
        ST_WAIT: begin
          if (alu_done) begin
            unique case (cur.dst)
              R_ANGLE: angle <= alu_res;
              R_BIAS:  bias  <= alu_res;
              R_COVA:  cova  <= alu_res;
              R_COVX:  covx  <= alu_res;
              R_COVB:  covb  <= alu_res;
              R_T:     t     <= alu_res;
              R_S:     s     <= alu_res;
              R_K0:    k0    <= alu_res;
              R_K1:    k1    <= alu_res;
              R_Y:     y     <= alu_res;
              default: ;
            endcase
            if (pc == PC_LAST) begin
              state <= ST_DONE;
            end else begin
              pc    <= pc + 5'd1;
              state <= ST_RUN;
            end
          end
        end
        default: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            angle_estimate <= ang_out;
            state          <= ST_IDLE;
          end
        end
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != ST_IDLE))
    else $error("accepted item left sequencer idle");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    alu_done |-> (state == ST_WAIT))
    else $error("alu result outside wait state");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result raised without finished item");

endmodule
